>>> sv/pjs_pkg.sv
// Package for the periodic job scheduler: sizes, command and status codes,
// the queued command type and the engine state enum. No dependencies.
package pjs_pkg;
  localparam int SLOTS         = 16;
  localparam int SLOT_BITS     = $clog2(SLOTS);
  localparam int INTERVAL_BITS = 32;
  localparam int COUNT_BITS    = 16;
  localparam int LIMIT_BITS    = 17;
  localparam int QDEPTH        = 2;

  typedef enum logic [2:0] {
    CMD_TICK   = 3'd0,
    CMD_ADD    = 3'd1,
    CMD_REMOVE = 3'd2,
    CMD_START  = 3'd3,
    CMD_STOP   = 3'd4,
    CMD_PAUSE  = 3'd5,
    CMD_RESUME = 3'd6,
    CMD_BAD    = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_REFUSED = 2'd1,
    ST_FIRED   = 2'd2,
    ST_UNUSED  = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t                           cmd;
    logic [3:0]                     job_id;
    logic [INTERVAL_BITS-1:0]       interval;
    logic                           immediate;
    logic signed [LIMIT_BITS-1:0]   run_cap;
  } job_cmd_t;

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_SCAN,
    ENG_ONE,
    ENG_FLUSH
  } eng_state_t;
endpackage

>>> sv/pjs_front.sv
// Front end: accepts stream items, unpacks them into commands and holds
// them in a short queue for the slot engine. Uses pjs_pkg.
module pjs_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tuser,   // cmd[2:0]
  input  logic [55:0]       in_tdata,   // job_id, interval, immediate, run_cap
  output logic              q_valid,
  input  logic              q_pop,
  output pjs_pkg::job_cmd_t q_cmd
);
  import pjs_pkg::*;

  job_cmd_t   mem_r [QDEPTH];
  logic [$clog2(QDEPTH):0] cnt_r, cnt_nxt;
  logic [$clog2(QDEPTH)-1:0] wp_r, rp_r;
  logic push;
  job_cmd_t item;

  always_comb begin
    item.cmd       = cmd_t'(in_tuser[2:0]);
    item.job_id    = in_tdata[3:0];
    item.interval  = in_tdata[35:4];
    item.immediate = in_tdata[36];
    item.run_cap   = in_tdata[53:37];
  end

  assign in_tready = (cnt_r != QDEPTH[$clog2(QDEPTH):0]);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != '0);
  assign q_cmd     = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !(q_pop && q_valid)) cnt_nxt = cnt_r + 1'b1;
    else if (!push && q_pop && q_valid) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r  <= '0;
      rp_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= wp_r + 1'b1;
      if (q_pop && q_valid) rp_r <= rp_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= item;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QDEPTH) else $error("queue count overflow");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == QDEPTH) |-> !push) else $error("push into full queue");
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !q_pop) |=> cnt_r == $past(cnt_r) + 1'b1) else $error("count step");
endmodule

>>> sv/pjs_engine.sv
// Back end: slot table, scanning sequencer (one slot per cycle while the output
// register is free) and an output register toward the result stream. Uses pjs_pkg.
module pjs_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_pop,
  input  pjs_pkg::job_cmd_t q_cmd,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,  // status[1:0], job_id_res[5:2]
  output logic              out_tlast
);
  import pjs_pkg::*;

  logic [SLOTS-1:0]                used_r, armed_r, first_r;
  logic [INTERVAL_BITS-1:0]        period_r [SLOTS];
  logic [INTERVAL_BITS-1:0]        cd_r     [SLOTS];
  logic signed [LIMIT_BITS-1:0]    maxr_r   [SLOTS];
  logic [COUNT_BITS-1:0]           runs_r   [SLOTS];
  logic running_r, paused_r;

  eng_state_t st_r, st_nxt;
  job_cmd_t   cur_r;
  logic [SLOT_BITS-1:0] idx_r;
  logic fired_r;            // any fire so far in this tick; command accepted otherwise
  logic pend_v_r;           // a fire waits for the next one to know last
  logic [SLOT_BITS-1:0] pend_id_r;

  logic [1:0] o_st_r;
  logic [3:0] o_id_r;
  logic       o_v_r, o_last_r;

  assign out_tvalid = o_v_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = {2'b00, o_id_r, o_st_r};

  logic oslot;
  assign oslot = !o_v_r || out_tready;

  // Lowest free slot
  logic [SLOT_BITS-1:0] free_id;
  logic                 free_ok;
  always_comb begin
    free_id = '0;
    free_ok = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_id = SLOT_BITS'(i);
        free_ok = 1'b1;
      end
    end
  end

  logic [INTERVAL_BITS-1:0] ivl_sat;
  assign ivl_sat = (q_cmd.interval == '0) ? INTERVAL_BITS'(1) : q_cmd.interval;

  // Success of a command, judged on the state before it takes effect
  logic take_ok;
  always_comb begin
    unique case (q_cmd.cmd)
      CMD_ADD:    take_ok = free_ok;
      CMD_STOP:   take_ok = running_r;
      CMD_PAUSE:  take_ok = running_r && !paused_r;
      CMD_RESUME: take_ok = paused_r;
      default:    take_ok = 1'b0;
    endcase
  end

  // scan-slot decision
  logic cur_act, cur_due, cur_may, cur_fire, scan_end;
  always_comb begin
    cur_act = used_r[idx_r] && armed_r[idx_r];
    cur_due = cur_act && (cd_r[idx_r] <= INTERVAL_BITS'(1));
    cur_may = maxr_r[idx_r][LIMIT_BITS-1] ||
              ({1'b0, runs_r[idx_r]} != LIMIT_BITS'(maxr_r[idx_r]));
    cur_fire = cur_due && cur_may;
    scan_end = (idx_r == SLOT_BITS'(SLOTS - 1));
  end

  // result emitted this cycle
  logic       emit;
  logic [1:0] e_st;
  logic [3:0] e_id;
  logic       e_last;
  logic       q_take;

  always_comb begin
    st_nxt = st_r;
    q_pop  = 1'b0;
    q_take = 1'b0;
    emit   = 1'b0;
    e_st   = ST_DONE;
    e_id   = '0;
    e_last = 1'b1;
    unique case (st_r)
      ENG_IDLE: begin
        if (q_valid) begin
          q_pop  = 1'b1;
          q_take = 1'b1;
          if (q_cmd.cmd == CMD_TICK && running_r && !paused_r) st_nxt = ENG_SCAN;
          else if (q_cmd.cmd == CMD_START && !running_r && !paused_r) st_nxt = ENG_SCAN;
          else st_nxt = ENG_ONE;
        end
      end
      ENG_SCAN: begin
        if (oslot) begin
          if (cur_r.cmd == CMD_TICK) begin
            if (cur_fire && pend_v_r) begin
              emit = 1'b1; e_st = ST_FIRED; e_id = 4'(pend_id_r); e_last = 1'b0;
            end
            if (scan_end) begin
              // a fire in the last slot after an earlier one goes out from ENG_FLUSH
              if (cur_fire && pend_v_r) begin
                st_nxt = ENG_FLUSH;
              end else begin
                if (cur_fire) begin
                  emit = 1'b1; e_st = ST_FIRED; e_id = 4'(idx_r); e_last = 1'b1;
                end else if (pend_v_r) begin
                  emit = 1'b1; e_st = ST_FIRED; e_id = 4'(pend_id_r); e_last = 1'b1;
                end else if (!fired_r) begin
                  emit = 1'b1; e_st = ST_DONE; e_id = '0; e_last = 1'b1;
                end
                st_nxt = ENG_IDLE;
              end
            end
          end else begin
            if (scan_end) begin
              emit = 1'b1;
              st_nxt = ENG_IDLE;
            end
          end
        end
      end
      ENG_FLUSH: begin
        if (oslot) begin
          emit = 1'b1; e_st = ST_FIRED; e_id = 4'(pend_id_r); e_last = 1'b1;
          st_nxt = ENG_IDLE;
        end
      end
      ENG_ONE: begin
        if (oslot) begin
          emit   = 1'b1;
          st_nxt = ENG_IDLE;
          unique case (cur_r.cmd)
            CMD_TICK:   e_st = ST_DONE;    // tick while stopped or paused
            CMD_ADD: begin
              e_st = fired_r ? ST_DONE : ST_REFUSED;
              e_id = fired_r ? 4'(pend_id_r) : 4'd0;
            end
            CMD_REMOVE: begin
              e_id = cur_r.job_id;
              e_st = (32'(cur_r.job_id) < SLOTS && used_r[SLOT_BITS'(cur_r.job_id)])
                     ? ST_DONE : ST_REFUSED;
            end
            CMD_STOP, CMD_PAUSE, CMD_RESUME: e_st = fired_r ? ST_DONE : ST_REFUSED;
            default:    e_st = ST_REFUSED;
          endcase
        end
      end
      default: st_nxt = ENG_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ENG_IDLE;
    else        st_r <= st_nxt;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (emit) begin
      o_v_r <= 1'b1;
    end else if (out_tready) begin
      o_v_r <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (emit) begin
      o_st_r   <= e_st;
      o_id_r   <= e_id;
      o_last_r <= e_last;
    end
  end

  // Control and table updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r    <= '0;
      armed_r   <= '0;
      running_r <= 1'b0;
      paused_r  <= 1'b0;
      idx_r     <= '0;
      fired_r   <= 1'b0;
      pend_v_r  <= 1'b0;
      for (int i = 0; i < SLOTS; i++) runs_r[i] <= '0;
    end else begin
      if (q_take) begin
        cur_r    <= q_cmd;
        idx_r    <= '0;
        fired_r  <= take_ok;
        pend_v_r <= 1'b0;
        // Add, stop, pause and resume take effect here; remove takes effect in ENG_ONE, where all give their result.
        unique case (q_cmd.cmd)
          CMD_ADD: begin
            pend_id_r <= free_id;
            if (free_ok) begin
              used_r[free_id]   <= 1'b1;
              period_r[free_id] <= ivl_sat;
              first_r[free_id]  <= q_cmd.immediate;
              maxr_r[free_id]   <= q_cmd.run_cap;
              runs_r[free_id]   <= '0;
              armed_r[free_id]  <= running_r;
              cd_r[free_id]     <= q_cmd.immediate ? INTERVAL_BITS'(1) : ivl_sat;
            end
          end
          CMD_REMOVE: ;
          CMD_STOP: begin
            if (running_r) begin
              running_r <= 1'b0;
              paused_r  <= 1'b0;
              armed_r   <= '0;
              for (int i = 0; i < SLOTS; i++) runs_r[i] <= '0;
            end
          end
          CMD_PAUSE:  if (running_r && !paused_r) paused_r <= 1'b1;
          CMD_RESUME: if (paused_r) paused_r <= 1'b0;
          default: ;
        endcase
      end
      if (st_r == ENG_ONE && oslot && cur_r.cmd == CMD_REMOVE &&
          32'(cur_r.job_id) < SLOTS) begin
        used_r[SLOT_BITS'(cur_r.job_id)]  <= 1'b0;
        armed_r[SLOT_BITS'(cur_r.job_id)] <= 1'b0;
      end
      if (st_r == ENG_SCAN && oslot) begin
        idx_r <= idx_r + 1'b1;
        if (cur_r.cmd == CMD_TICK) begin
          if (cur_act) begin
            if (!cur_due) begin
              cd_r[idx_r] <= cd_r[idx_r] - 1'b1;
            end else if (cur_may) begin
              if (runs_r[idx_r] != '1) runs_r[idx_r] <= runs_r[idx_r] + 1'b1;
              cd_r[idx_r] <= period_r[idx_r];
              fired_r     <= 1'b1;
              pend_v_r    <= 1'b1;
              pend_id_r   <= idx_r;
            end else begin
              armed_r[idx_r] <= 1'b0;
            end
          end
        end else begin
          if (used_r[idx_r]) begin
            armed_r[idx_r] <= 1'b1;
            cd_r[idx_r] <= (first_r[idx_r] && runs_r[idx_r] == '0)
                           ? INTERVAL_BITS'(1) : period_r[idx_r];
          end
          if (scan_end) running_r <= 1'b1;
        end
      end
    end
  end

  a_pause_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
    paused_r |-> running_r) else $error("paused while stopped");
  a_armed_used: assert property (@(posedge clk) disable iff (!rst_n)
    (armed_r & ~used_r) == '0 || st_r != ENG_IDLE) else $error("armed unused slot");
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (!o_v_r || out_tready)) else $error("output overwritten");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> st_r == ENG_IDLE) else $error("pop while busy");
endmodule

>>> sv/periodic_job_scheduler_unit.sv
// Periodic job scheduler top level. A tick or start scans every slot, one slot
// per cycle while the result register is free; a tick firing the last slot after
// an earlier one adds an ENG_FLUSH state. Other commands go through ENG_ONE.
// The engine takes the next command only when idle; a two-entry queue decouples input.
// Reset (rst_n low, synchronous) clears slots, run counts, running, paused.
// Uses pjs_pkg, pjs_front and pjs_engine.
module periodic_job_scheduler_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tuser,    // cmd[2:0]
  input  logic [55:0] in_tdata,    // job_id[3:0], interval[35:4],
                                   // immediate[36], run cap[53:37]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // status[1:0], job_id_res[5:2]
  output logic        out_tlast
);
  import pjs_pkg::*;

  logic     q_valid, q_pop;
  job_cmd_t q_cmd;

  // Front: stream intake and command queue
  pjs_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tuser, .in_tdata,
    .q_valid, .q_pop, .q_cmd
  );

  // Back: slot table, scan sequencer, result register
  pjs_engine u_engine (
    .clk, .rst_n, .q_valid, .q_pop, .q_cmd,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast
  );
endmodule
